// File: src/fds_pkg.sv
package fds_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_SUBSTEPS = 2048;
  localparam int SUB_W        = $clog2(MAX_SUBSTEPS + 1);

  localparam int AW  = 49;
  localparam int BW  = 32;
  localparam int DW  = 32;
  localparam int PW  = AW + BW;
  localparam int RW  = 64;
  localparam int CNT_W = $clog2(PW + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_TIME  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_TIME = 2'd3;

  localparam logic [23:0] GAIN_RST = 24'd65536;
  localparam logic [23:0] TIME_RST = 24'd20000;
  // ceil(2^22 / 5): exact x/5 for any x below 2^22
  localparam logic [19:0] H_RECIP  = 20'd838861;

  localparam logic signed [63:0] S48_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] S48_MIN = -(64'sd1 <<< 47);
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic               op;
    logic [31:0]        sample_time;
    logic signed [31:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [31:0] filtered_derivative;
    logic               substeps_clipped;
  } out_t;

  typedef struct packed {
    logic          start;
    logic [AW-1:0] a;
    logic [BW-1:0] b;
    logic          neg;
    logic [DW-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [RW-1:0] res;
  } md_rsp_t;

  function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] n;
    n = -v;
    return v[AW-1] ? AW'(n) : AW'(v);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > S48_MAX) ? S48_MAX : ((v < S48_MIN) ? S48_MIN : v);
    return c[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
    return c[31:0];
  endfunction

endpackage

// File: src/fds_muldiv.sv
module fds_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  fds_pkg::md_req_t req,
  output fds_pkg::md_rsp_t rsp
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;
  localparam logic [1:0] P_FIN  = 2'd3;

  localparam logic [fds_pkg::PW-1:0] CAP = fds_pkg::PW'(1) << 62;

  logic [1:0]                   phase_r, phase_nxt;
  logic [fds_pkg::PW-1:0]       acc_r, acc_nxt;
  logic [fds_pkg::PW-1:0]       mc_r, mc_nxt;
  logic [fds_pkg::BW-1:0]       mp_r, mp_nxt;
  logic [fds_pkg::DW-1:0]       d_r, d_nxt;
  logic [fds_pkg::DW-1:0]       rem_r, rem_nxt;
  logic [fds_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         neg_r, neg_nxt;
  logic                         done_r, done_nxt;
  logic signed [fds_pkg::RW-1:0] res_r, res_nxt;

  logic [fds_pkg::DW:0]   rem_sh;
  logic                   ge;
  logic [fds_pkg::PW-1:0] qv;
  logic [fds_pkg::RW-1:0] qm;

  always_comb begin
    rem_sh = {rem_r, acc_r[fds_pkg::PW-1]};
    ge     = rem_sh >= {1'b0, d_r};
    qv     = (acc_r > CAP) ? CAP : acc_r;
    qm     = {1'b0, qv[fds_pkg::RW-2:0]};
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    mc_nxt    = mc_r;
    mp_nxt    = mp_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    case (phase_r)
      P_IDLE: begin
        if (req.start) begin
          acc_nxt   = '0;
          mc_nxt    = fds_pkg::PW'(req.a);
          mp_nxt    = req.b;
          d_nxt     = (req.d == '0) ? fds_pkg::DW'(1) : req.d;
          neg_nxt   = req.neg;
          phase_nxt = P_MUL;
        end
      end
      P_MUL: begin
        if (mp_r == '0) begin
          rem_nxt = '0;
          cnt_nxt = fds_pkg::CNT_W'(fds_pkg::PW);
          phase_nxt = (d_r == fds_pkg::DW'(1)) ? P_FIN : P_DIV;
        end else begin
          if (mp_r[0]) begin
            acc_nxt = acc_r + mc_r;
          end
          mc_nxt = mc_r << 1;
          mp_nxt = mp_r >> 1;
        end
      end
      P_DIV: begin
        rem_nxt = ge ? fds_pkg::DW'(rem_sh - {1'b0, d_r}) : rem_sh[fds_pkg::DW-1:0];
        acc_nxt = {acc_r[fds_pkg::PW-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == fds_pkg::CNT_W'(1)) begin
          phase_nxt = P_FIN;
        end
      end
      P_FIN: begin
        res_nxt   = neg_r ? -$signed(qm) : $signed(qm);
        done_nxt  = 1'b1;
        phase_nxt = P_IDLE;
      end
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// File: src/filtered_derivative_substep.sv
// Filtered derivative (washout) on timestamped samples, Q16.16 data, integer tick times.
// One request is taken at a time; in_ready is low until its result has been loaded into
// the output register, which can still hold a result while the next request is taken.
// All products and quotients go through one shared shift-add multiplier and restoring
// divider; each use multiplies, then divides unless the divisor is one. An initialize or
// a steady-state jump takes one use; an advance takes one use for the substep count (none
// when no time has passed), four per full Euler substep (interpolate, derivative, lag,
// filter) and three for the final partial step (derivative, lag, filter).
module filtered_derivative_substep (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fds_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fds_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [fds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fds_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_INIT   = 4'd1;
  localparam logic [3:0] ST_N      = 4'd3;
  localparam logic [3:0] ST_LOOP   = 4'd4;
  localparam logic [3:0] ST_INTERP = 4'd5;
  localparam logic [3:0] ST_DV     = 4'd6;
  localparam logic [3:0] ST_LAG    = 4'd7;
  localparam logic [3:0] ST_FILT   = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;

  logic signed [23:0] gain_r;
  logic signed [31:0] bias_r;
  logic [23:0]        t1_r, t2_r;

  logic [3:0]  state_r, state_nxt;
  logic        issued_r, issued_nxt;
  logic [31:0] time_r, time_nxt;
  logic signed [31:0] u_r, u_nxt;
  logic [31:0] dt_r, dt_nxt;
  logic [31:0] h_r, h_nxt;
  logic [fds_pkg::SUB_W-1:0] cnt_r, cnt_nxt;
  logic [31:0] ih_r, ih_nxt;
  logic [31:0] dur_r, dur_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic signed [31:0] cur_r, cur_nxt;
  logic signed [47:0] dv_r, dv_nxt;
  logic        final_r, final_nxt;
  logic        clip_r, clip_nxt;
  logic signed [47:0] lag_r, lag_nxt;
  logic signed [47:0] filt_r, filt_nxt;
  logic signed [31:0] last_in_r, last_in_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic        out_valid_r, out_valid_nxt;
  fds_pkg::out_t out_data_r, out_data_nxt;

  fds_pkg::md_req_t req;
  fds_pkg::md_rsp_t rsp;

  logic [23:0] t1e, t2e, tmin;
  logic [26:0] t1x5, t2x5;
  logic [41:0] h_prod;
  logic [31:0] h_calc;
  logic [31:0] dt_in;
  logic        jump;
  logic signed [31:0] u_in;
  logic [fds_pkg::AW-1:0] k_mag;
  logic signed [32:0] diff, avg;
  logic signed [fds_pkg::AW-1:0] err, fdel;
  logic signed [63:0] lag_sum, filt_sum, cur_sum;
  logic signed [63:0] res_sh;
  logic in_acc, op_state;

  fds_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= fds_pkg::GAIN_RST;
      bias_r <= '0;
      t1_r   <= fds_pkg::TIME_RST;
      t2_r   <= fds_pkg::TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fds_pkg::REG_GAIN:      gain_r <= cfg_data[23:0];
        fds_pkg::REG_BIAS:      bias_r <= cfg_data;
        fds_pkg::REG_LAG_TIME:  t1_r   <= cfg_data[23:0];
        fds_pkg::REG_FILT_TIME: t2_r   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    t1e   = (t1_r == '0) ? 24'd1 : t1_r;
    t2e   = (t2_r == '0) ? 24'd1 : t2_r;
    tmin  = (t1e < t2e) ? t1e : t2e;
    h_prod = 42'(tmin[23:2]) * 42'(fds_pkg::H_RECIP);
    h_calc = (h_prod[41:22] == '0) ? 32'd1 : 32'(h_prod[41:22]);
    t1x5  = {1'b0, t1e, 2'b00} + 27'(t1e);
    t2x5  = {1'b0, t2e, 2'b00} + 27'(t2e);
    dt_in = in_data.sample_time - last_time_r;
    jump  = (dt_in >= 32'(t1x5)) && (dt_in >= 32'(t2x5));
    u_in  = fds_pkg::sat32(64'(in_data.sample) + 64'(bias_r));
    k_mag = fds_pkg::mag(fds_pkg::AW'(gain_r));
    diff  = 33'(u_r) - 33'(last_in_r);
    avg   = (33'(prev_r) + 33'(cur_r)) >>> 1;
    err   = fds_pkg::AW'(avg) - fds_pkg::AW'(lag_r);
    fdel  = fds_pkg::AW'(dv_r) - fds_pkg::AW'(filt_r);
    lag_sum  = 64'(lag_r) + rsp.res;
    filt_sum = 64'(filt_r) + rsp.res;
    cur_sum  = 64'(last_in_r) + rsp.res;
    res_sh   = rsp.res >>> fds_pkg::FRAC_BITS;
    in_acc   = in_valid && in_ready;
    op_state = (state_r == ST_INIT) || (state_r == ST_N) ||
               (state_r == ST_INTERP) || (state_r == ST_DV) || (state_r == ST_LAG) ||
               (state_r == ST_FILT);
  end

  always_comb begin
    req.start = op_state && !issued_r;
    req.a     = '0;
    req.b     = 32'd1;
    req.neg   = 1'b0;
    req.d     = 32'd1;
    case (state_r)
      ST_INIT: begin
        req.a   = fds_pkg::mag(fds_pkg::AW'(u_r));
        req.b   = 32'(k_mag);
        req.neg = u_r[31] ^ gain_r[23];
      end
      ST_N: begin
        req.a = fds_pkg::AW'(dt_r - 32'd1);
        req.d = h_r;
      end
      ST_INTERP: begin
        req.a   = fds_pkg::mag(fds_pkg::AW'(diff));
        req.b   = ih_r;
        req.neg = diff[32];
        req.d   = dt_r;
      end
      ST_DV: begin
        req.a   = fds_pkg::mag(err);
        req.b   = 32'(k_mag);
        req.neg = err[fds_pkg::AW-1] ^ gain_r[23];
        req.d   = 32'(t1e);
      end
      ST_LAG: begin
        req.a   = fds_pkg::mag(fds_pkg::AW'(dv_r));
        req.b   = dur_r;
        req.neg = dv_r[47];
      end
      ST_FILT: begin
        req.a   = fds_pkg::mag(fdel);
        req.b   = dur_r;
        req.neg = fdel[fds_pkg::AW-1];
        req.d   = 32'(t2e);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    time_nxt      = time_r;
    u_nxt         = u_r;
    dt_nxt        = dt_r;
    h_nxt         = h_r;
    cnt_nxt       = cnt_r;
    ih_nxt        = ih_r;
    dur_nxt       = dur_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    dv_nxt        = dv_r;
    final_nxt     = final_r;
    clip_nxt      = clip_r;
    lag_nxt       = lag_r;
    filt_nxt      = filt_r;
    last_in_nxt   = last_in_r;
    last_time_nxt = last_time_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (req.start) begin
      issued_nxt = 1'b1;
    end
    if (rsp.done) begin
      issued_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          time_nxt  = in_data.sample_time;
          u_nxt     = u_in;
          dt_nxt    = dt_in;
          prev_nxt  = last_in_r;
          clip_nxt  = 1'b0;
          h_nxt     = h_calc;
          ih_nxt    = '0;
          cnt_nxt   = '0;
          if (!in_data.op || jump) begin
            state_nxt = ST_INIT;
          end else begin
            state_nxt = (dt_in == '0) ? ST_LOOP : ST_N;
          end
        end
      end
      ST_INIT: begin
        if (rsp.done) begin
          lag_nxt   = res_sh[47:0];
          filt_nxt  = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_N: begin
        if (rsp.done) begin
          if (rsp.res > 64'(fds_pkg::MAX_SUBSTEPS)) begin
            cnt_nxt  = fds_pkg::SUB_W'(fds_pkg::MAX_SUBSTEPS);
            clip_nxt = 1'b1;
          end else begin
            cnt_nxt = rsp.res[fds_pkg::SUB_W-1:0];
          end
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (cnt_r != '0) begin
          ih_nxt    = ih_r + h_r;
          dur_nxt   = h_r;
          cnt_nxt   = cnt_r - 1'b1;
          final_nxt = 1'b0;
          state_nxt = ST_INTERP;
        end else begin
          cur_nxt   = u_r;
          dur_nxt   = dt_r - ih_r;
          final_nxt = 1'b1;
          state_nxt = ST_DV;
        end
      end
      ST_INTERP: begin
        if (rsp.done) begin
          cur_nxt   = cur_sum[31:0];
          state_nxt = ST_DV;
        end
      end
      ST_DV: begin
        if (rsp.done) begin
          dv_nxt    = fds_pkg::sat48(res_sh);
          state_nxt = ST_LAG;
        end
      end
      ST_LAG: begin
        if (rsp.done) begin
          lag_nxt   = fds_pkg::sat48(lag_sum);
          state_nxt = ST_FILT;
        end
      end
      ST_FILT: begin
        if (rsp.done) begin
          filt_nxt  = fds_pkg::sat48(filt_sum);
          prev_nxt  = cur_r;
          state_nxt = final_r ? ST_FIN : ST_LOOP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.filtered_derivative = fds_pkg::sat32(64'(filt_r));
          out_data_nxt.substeps_clipped    = clip_r;
          out_valid_nxt = 1'b1;
          last_in_nxt   = u_r;
          last_time_nxt = time_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      lag_r       <= '0;
      filt_r      <= '0;
      last_in_r   <= '0;
      last_time_r <= '0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      lag_r       <= lag_nxt;
      filt_r      <= filt_nxt;
      last_in_r   <= last_in_nxt;
      last_time_r <= last_time_nxt;
    end
    time_r     <= time_nxt;
    u_r        <= u_nxt;
    dt_r       <= dt_nxt;
    h_r        <= h_nxt;
    cnt_r      <= cnt_nxt;
    ih_r       <= ih_nxt;
    dur_r      <= dur_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    dv_r       <= dv_nxt;
    final_r    <= final_nxt;
    clip_r     <= clip_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/fds_checker.sv
module fds_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input fds_pkg::out_t                  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready while a request is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in work");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind filtered_derivative_substep fds_checker u_fds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
